@@ src/lcp_pkg.sv @@
// ----------------------------------------------------------------------------
// lcp_pkg: shared types and constants for the closest points unit
// Item structs for both directions and the digit size of the multipliers.
// ----------------------------------------------------------------------------
package lcp_pkg;

    // coordinate width, signed fixed point
    localparam int COORD_WIDTH = 32;
    // operand digit handled by one multiplier stage
    localparam int MUL_DIGIT   = 16;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_origin_x;
        logic signed [COORD_WIDTH-1:0] a_origin_y;
        logic signed [COORD_WIDTH-1:0] a_origin_z;
        logic signed [COORD_WIDTH-1:0] a_dir_x;
        logic signed [COORD_WIDTH-1:0] a_dir_y;
        logic signed [COORD_WIDTH-1:0] a_dir_z;
        logic signed [COORD_WIDTH-1:0] b_origin_x;
        logic signed [COORD_WIDTH-1:0] b_origin_y;
        logic signed [COORD_WIDTH-1:0] b_origin_z;
        logic signed [COORD_WIDTH-1:0] b_dir_x;
        logic signed [COORD_WIDTH-1:0] b_dir_y;
        logic signed [COORD_WIDTH-1:0] b_dir_z;
    } t_in;

    typedef struct packed {
        logic                          found;
        logic signed [COORD_WIDTH-1:0] near_a_x;
        logic signed [COORD_WIDTH-1:0] near_a_y;
        logic signed [COORD_WIDTH-1:0] near_a_z;
        logic signed [COORD_WIDTH-1:0] near_b_x;
        logic signed [COORD_WIDTH-1:0] near_b_y;
        logic signed [COORD_WIDTH-1:0] near_b_z;
    } t_out;

endpackage

@@ src/lcp_mul.sv @@
// ----------------------------------------------------------------------------
// lcp_mul: pipelined signed multiplier
// Operand b is consumed one digit per stage; a partial product is added to
// the running sum in each stage.
// ----------------------------------------------------------------------------
module lcp_mul import lcp_pkg::*; #(
    parameter int AW = 33,
    parameter int BW = 32
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int ND  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BPW = ND * MUL_DIGIT;
    localparam int ACW = AW + BPW + 1;

    logic signed [BPW-1:0] b_ext;
    logic signed [AW-1:0]  r_a   [ND];
    logic        [BPW-1:0] r_b   [ND];
    logic signed [ACW-1:0] r_acc [ND];

    // sign extend b to whole digits
    assign b_ext = BPW'(i_b);

    for (genvar k = 0; k < ND; k++) begin : g_stage
        logic signed [AW-1:0]          a_in;
        logic        [BPW-1:0]         b_in;
        logic signed [ACW-1:0]         acc_in;
        logic        [MUL_DIGIT-1:0]   dig;
        logic signed [AW+MUL_DIGIT:0]  prod;
        logic signed [ACW-1:0]         pp;

        if (k == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = b_ext;
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign acc_in = r_acc[k-1];
        end

        assign dig = b_in[k*MUL_DIGIT +: MUL_DIGIT];

        // top digit carries the sign, lower digits are unsigned
        if (k == ND - 1) begin : g_top
            assign prod = $signed(a_in) * $signed(dig);
        end else begin : g_low
            assign prod = $signed(a_in) * $signed({1'b0, dig});
        end

        assign pp = ACW'(prod) <<< (k * MUL_DIGIT);

        always_ff @(posedge i_clk) begin
            r_a[k]   <= a_in;
            r_b[k]   <= b_in;
            r_acc[k] <= acc_in + pp;
        end
    end

    assign o_p = r_acc[ND-1][AW+BW-1:0];

endmodule

@@ src/lcp_div.sv @@
// ----------------------------------------------------------------------------
// lcp_div: pipelined restoring divider with overflow detect
// Divides a signed dividend by a positive divisor, truncating toward zero.
// Returns the low QB quotient magnitude bits, the sign and a flag that the
// magnitude needs more than QB bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module lcp_div import lcp_pkg::*; #(
    parameter int PW = 165,
    parameter int NW = 133,
    parameter int QB = 33
) (
    input  logic                 i_clk,
    input  logic signed [PW-1:0] i_p,
    input  logic signed [NW-1:0] i_d,
    output logic        [QB-1:0] o_q,
    output logic                 o_neg,
    output logic                 o_ovf
);

    localparam int RW = NW + 1;
    localparam int CW = (PW > NW + QB) ? PW : NW + QB;
    localparam int MW = (PW > RW) ? PW : RW;

    logic          neg;
    logic [PW-1:0] mag;
    logic [NW-1:0] dm;
    logic          ovf;
    logic [MW-1:0] mx;

    logic [RW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [NW-1:0] r_d   [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];

    // magnitude, overflow check and upper remainder
    assign neg = i_p[PW-1];
    assign mag = neg ? (~i_p + 1'b1) : i_p;
    assign dm  = i_d;
    assign ovf = CW'(mag) >= (CW'(dm) << QB);
    assign mx  = MW'(mag) >> QB;

    always_ff @(posedge i_clk) begin
        r_rem[0] <= mx[RW-1:0];
        r_low[0] <= mag[QB-1:0];
        r_q[0]   <= '0;
        r_d[0]   <= dm;
        r_neg[0] <= neg;
        r_ovf[0] <= ovf;
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QB; k++) begin : g_bit
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = {r_rem[k-1][RW-2:0], r_low[k-1][QB-k]};
        assign ge    = trial >= {1'b0, r_d[k-1]};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? (trial - {1'b0, r_d[k-1]}) : trial;
            r_low[k] <= r_low[k-1];
            r_q[k]   <= {r_q[k-1][QB-2:0], ge};
            r_d[k]   <= r_d[k-1];
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    assign o_q   = r_q[QB];
    assign o_neg = r_neg[QB];
    assign o_ovf = r_ovf[QB];

endmodule

@@ src/line_closest_points_3d_unit.sv @@
// ----------------------------------------------------------------------------
// line_closest_points_3d_unit: closest points between two 3D lines
// Finds the common perpendicular of two lines and returns its foot on each.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle (busy is low outside reset) and
// results come out in the order the items were taken. The path runs
// through the three multiplier passes, each one digit of 16 bits per stage,
// and the divider, one quotient bit per stage. Results cannot be held off:
// o_done and o_item are valid for one cycle only. found is low and all
// points are zero for parallel or degenerate lines.
// ----------------------------------------------------------------------------
module line_closest_points_3d_unit import lcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_done,
    output t_out o_item
);

    localparam int W   = COORD_WIDTH;
    localparam int PW1 = 2 * W + 1;
    localparam int DW  = 2 * W + 3;
    localparam int PW2 = 2 * DW;
    localparam int NW  = 2 * DW + 1;
    localparam int PW3 = NW + W;
    localparam int QB  = W + 1;
    localparam int L1  = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int L2  = (DW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int L3  = (NW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int I2  = L1 + 1;
    localparam int I3  = I2 + L2 + 1;
    localparam int I4  = I3 + L3;
    localparam int I5  = I4 + 1 + QB;
    localparam int LAT = I5 + 2;

    localparam logic signed [W+2:0] SMAX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] SMIN = {4'b1111, {(W-1){1'b0}}};

    logic acc;

    // item line and valid bits
    t_in  r_line [I5+1];
    logic r_vld  [I5+1];
    logic r_out_vld;
    t_out r_out;

    // first product stage operands
    logic signed [W-1:0] s_ad [3];
    logic signed [W-1:0] s_bd [3];
    logic signed [W:0]   s_adx [3];
    logic signed [W:0]   s_bdx [3];
    logic signed [W:0]   s_w  [3];
    logic signed [PW1-1:0] p_aa [3];
    logic signed [PW1-1:0] p_bb [3];
    logic signed [PW1-1:0] p_ab [3];
    logic signed [PW1-1:0] p_wa [3];
    logic signed [PW1-1:0] p_wb [3];

    // dot products
    logic signed [DW-1:0] r_aa, r_bb, r_ab, r_wa, r_wb;

    // second product stage
    logic signed [PW2-1:0] p_aabb, p_abab, p_bbwa, p_abwb, p_abwa, p_aawb;
    logic signed [NW-1:0]  r_d, r_nt, r_no;
    logic                  found;
    logic signed [NW-1:0]  r_dd  [L3];
    logic                  r_fnd [I5-I3];

    // third product stage and division
    logic signed [W-1:0]   s_dir3 [6];
    logic signed [PW3-1:0] p_dn   [6];
    logic        [QB-1:0]  q_mag  [6];
    logic                  q_neg  [6];
    logic                  q_ovf  [6];
    logic signed [W-1:0]   s_org  [6];
    logic signed [W-1:0]   s_pt   [6];

    assign busy = ~i_rst_n;
    assign acc  = start & ~busy;

    // item shift line with valid bits
    always_ff @(posedge i_clk) begin
        r_line[0] <= i_item;
        for (int k = 1; k <= I5; k++) begin
            r_line[k] <= r_line[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= I5; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= acc;
            for (int k = 1; k <= I5; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[I5];
        end
    end

    // per-axis operands of the first stage
    assign s_ad[0] = r_line[0].a_dir_x;
    assign s_ad[1] = r_line[0].a_dir_y;
    assign s_ad[2] = r_line[0].a_dir_z;
    assign s_bd[0] = r_line[0].b_dir_x;
    assign s_bd[1] = r_line[0].b_dir_y;
    assign s_bd[2] = r_line[0].b_dir_z;
    assign s_w[0]  = (W+1)'(r_line[0].b_origin_x) - (W+1)'(r_line[0].a_origin_x);
    assign s_w[1]  = (W+1)'(r_line[0].b_origin_y) - (W+1)'(r_line[0].a_origin_y);
    assign s_w[2]  = (W+1)'(r_line[0].b_origin_z) - (W+1)'(r_line[0].a_origin_z);

    for (genvar i = 0; i < 3; i++) begin : g_dot
        assign s_adx[i] = (W+1)'(s_ad[i]);
        assign s_bdx[i] = (W+1)'(s_bd[i]);

        lcp_mul #(.AW(W+1), .BW(W)) u_aa (
            .i_clk(i_clk), .i_a(s_adx[i]), .i_b(s_ad[i]), .o_p(p_aa[i]));
        lcp_mul #(.AW(W+1), .BW(W)) u_bb (
            .i_clk(i_clk), .i_a(s_bdx[i]), .i_b(s_bd[i]), .o_p(p_bb[i]));
        lcp_mul #(.AW(W+1), .BW(W)) u_ab (
            .i_clk(i_clk), .i_a(s_adx[i]), .i_b(s_bd[i]), .o_p(p_ab[i]));
        lcp_mul #(.AW(W+1), .BW(W)) u_wa (
            .i_clk(i_clk), .i_a(s_w[i]), .i_b(s_ad[i]), .o_p(p_wa[i]));
        lcp_mul #(.AW(W+1), .BW(W)) u_wb (
            .i_clk(i_clk), .i_a(s_w[i]), .i_b(s_bd[i]), .o_p(p_wb[i]));
    end

    // sum the axis products
    always_ff @(posedge i_clk) begin
        r_aa <= DW'(p_aa[0]) + DW'(p_aa[1]) + DW'(p_aa[2]);
        r_bb <= DW'(p_bb[0]) + DW'(p_bb[1]) + DW'(p_bb[2]);
        r_ab <= DW'(p_ab[0]) + DW'(p_ab[1]) + DW'(p_ab[2]);
        r_wa <= DW'(p_wa[0]) + DW'(p_wa[1]) + DW'(p_wa[2]);
        r_wb <= DW'(p_wb[0]) + DW'(p_wb[1]) + DW'(p_wb[2]);
    end

    // gram determinant and numerators
    lcp_mul #(.AW(DW), .BW(DW)) u_aabb (
        .i_clk(i_clk), .i_a(r_aa), .i_b(r_bb), .o_p(p_aabb));
    lcp_mul #(.AW(DW), .BW(DW)) u_abab (
        .i_clk(i_clk), .i_a(r_ab), .i_b(r_ab), .o_p(p_abab));
    lcp_mul #(.AW(DW), .BW(DW)) u_bbwa (
        .i_clk(i_clk), .i_a(r_bb), .i_b(r_wa), .o_p(p_bbwa));
    lcp_mul #(.AW(DW), .BW(DW)) u_abwb (
        .i_clk(i_clk), .i_a(r_ab), .i_b(r_wb), .o_p(p_abwb));
    lcp_mul #(.AW(DW), .BW(DW)) u_abwa (
        .i_clk(i_clk), .i_a(r_ab), .i_b(r_wa), .o_p(p_abwa));
    lcp_mul #(.AW(DW), .BW(DW)) u_aawb (
        .i_clk(i_clk), .i_a(r_aa), .i_b(r_wb), .o_p(p_aawb));

    always_ff @(posedge i_clk) begin
        r_d  <= NW'(p_aabb) - NW'(p_abab);
        r_nt <= NW'(p_bbwa) - NW'(p_abwb);
        r_no <= NW'(p_abwa) - NW'(p_aawb);
    end

    assign found = ~r_d[NW-1] & (|r_d);

    // divisor and found flag follow their item
    always_ff @(posedge i_clk) begin
        r_dd[0]  <= r_d;
        for (int k = 1; k < L3; k++) begin
            r_dd[k] <= r_dd[k-1];
        end
        r_fnd[0] <= found;
        for (int k = 1; k < I5 - I3; k++) begin
            r_fnd[k] <= r_fnd[k-1];
        end
    end

    // direction components and origins by coordinate
    assign s_dir3[0] = r_line[I3].a_dir_x;
    assign s_dir3[1] = r_line[I3].a_dir_y;
    assign s_dir3[2] = r_line[I3].a_dir_z;
    assign s_dir3[3] = r_line[I3].b_dir_x;
    assign s_dir3[4] = r_line[I3].b_dir_y;
    assign s_dir3[5] = r_line[I3].b_dir_z;
    assign s_org[0]  = r_line[I5].a_origin_x;
    assign s_org[1]  = r_line[I5].a_origin_y;
    assign s_org[2]  = r_line[I5].a_origin_z;
    assign s_org[3]  = r_line[I5].b_origin_x;
    assign s_org[4]  = r_line[I5].b_origin_y;
    assign s_org[5]  = r_line[I5].b_origin_z;

    for (genvar j = 0; j < 6; j++) begin : g_pt
        logic signed [W+2:0] qs;
        logic signed [W+2:0] sum;

        // scale the direction, then divide by the determinant
        lcp_mul #(.AW(W), .BW(NW)) u_dn (
            .i_clk(i_clk), .i_a(s_dir3[j]), .i_b((j < 3) ? r_nt : r_no),
            .o_p(p_dn[j]));

        lcp_div #(.PW(PW3), .NW(NW), .QB(QB)) u_div (
            .i_clk(i_clk), .i_p(p_dn[j]), .i_d(r_dd[L3-1]),
            .o_q(q_mag[j]), .o_neg(q_neg[j]), .o_ovf(q_ovf[j]));

        // add origin and saturate
        assign qs  = q_neg[j] ? -$signed({2'b00, q_mag[j]}) : $signed({2'b00, q_mag[j]});
        assign sum = qs + (W+3)'(s_org[j]);

        always_comb begin
            if (!r_fnd[I5-I3-1]) begin
                s_pt[j] = '0;
            end else if (q_ovf[j]) begin
                s_pt[j] = q_neg[j] ? SMIN[W-1:0] : SMAX[W-1:0];
            end else if (sum > SMAX) begin
                s_pt[j] = SMAX[W-1:0];
            end else if (sum < SMIN) begin
                s_pt[j] = SMIN[W-1:0];
            end else begin
                s_pt[j] = sum[W-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_out.found    <= r_fnd[I5-I3-1];
        r_out.near_a_x <= s_pt[0];
        r_out.near_a_y <= s_pt[1];
        r_out.near_a_z <= s_pt[2];
        r_out.near_b_x <= s_pt[3];
        r_out.near_b_y <= s_pt[4];
        r_out.near_b_z <= s_pt[5];
    end

    assign o_done = r_out_vld;
    assign o_item = r_out;

`ifndef SYNTHESIS
    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == $past(start && !busy, LAT))
        else $error("result strobe does not match accepted item");

    // a result without a solution carries zero points
    a_zero_pts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_item.found) |-> (o_item.near_a_x == 0 && o_item.near_a_y == 0
        && o_item.near_a_z == 0 && o_item.near_b_x == 0 && o_item.near_b_y == 0
        && o_item.near_b_z == 0))
        else $error("points not zero for parallel lines");
`endif

endmodule

@@ dv/line_closest_points_3d_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_closest_points_3d_unit_tb: self-checking bench for the closest points unit
// Drives a directed table of line pairs, then random pairs in several idling
// phases. Each result is checked against a fixed want or an exact wide-integer
// model of the common perpendicular, with saturation and parallel-line flagging.
// ----------------------------------------------------------------------------
module line_closest_points_3d_unit_tb import lcp_pkg::*; ();

    typedef logic signed [255:0] t_wide;

    localparam int ONE = 1 << 16;

    typedef struct {
        t_in  item;
        bit   fixed;
        t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_item;
    logic busy;
    logic o_done;
    t_out o_item;

    t_out pending_points[$];
    int   mismatches;

    line_closest_points_3d_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_item  (o_item)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // clamp a wide value to the signed coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -(t_wide'(1) <<< (COORD_WIDTH - 1));
        if (v > hi) return hi[COORD_WIDTH-1:0];
        if (v < lo) return lo[COORD_WIDTH-1:0];
        return v[COORD_WIDTH-1:0];
    endfunction

    // exact common perpendicular feet on both lines
    function automatic t_out closest_points(t_in v);
        t_wide ao[3], ad[3], bo[3], bd[3], w[3];
        t_wide aa, bb, ab, wa, wb, det, num_a, num_b;
        t_out  r;
        ao[0] = v.a_origin_x; ao[1] = v.a_origin_y; ao[2] = v.a_origin_z;
        ad[0] = v.a_dir_x;    ad[1] = v.a_dir_y;    ad[2] = v.a_dir_z;
        bo[0] = v.b_origin_x; bo[1] = v.b_origin_y; bo[2] = v.b_origin_z;
        bd[0] = v.b_dir_x;    bd[1] = v.b_dir_y;    bd[2] = v.b_dir_z;
        aa = 0; bb = 0; ab = 0; wa = 0; wb = 0;
        for (int i = 0; i < 3; i++) begin
            w[i] = bo[i] - ao[i];
            aa += ad[i] * ad[i];
            bb += bd[i] * bd[i];
            ab += ad[i] * bd[i];
            wa += w[i] * ad[i];
            wb += w[i] * bd[i];
        end
        det = aa * bb - ab * ab;
        r = '0;
        if (det <= 0) return r;
        num_a = bb * wa - ab * wb;
        num_b = ab * wa - aa * wb;
        r.found    = 1'b1;
        r.near_a_x = clamp_coord(ao[0] + (ad[0] * num_a) / det);
        r.near_a_y = clamp_coord(ao[1] + (ad[1] * num_a) / det);
        r.near_a_z = clamp_coord(ao[2] + (ad[2] * num_a) / det);
        r.near_b_x = clamp_coord(bo[0] + (bd[0] * num_b) / det);
        r.near_b_y = clamp_coord(bo[1] + (bd[1] * num_b) / det);
        r.near_b_z = clamp_coord(bo[2] + (bd[2] * num_b) / det);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result", o_item.found, 0);
            end else begin
                want = pending_points.pop_front();
                if (o_item.found !== want.found)
                    report_mismatch("found", o_item.found, want.found);
                if (o_item.near_a_x !== want.near_a_x)
                    report_mismatch("near_a_x", o_item.near_a_x, want.near_a_x);
                if (o_item.near_a_y !== want.near_a_y)
                    report_mismatch("near_a_y", o_item.near_a_y, want.near_a_y);
                if (o_item.near_a_z !== want.near_a_z)
                    report_mismatch("near_a_z", o_item.near_a_z, want.near_a_z);
                if (o_item.near_b_x !== want.near_b_x)
                    report_mismatch("near_b_x", o_item.near_b_x, want.near_b_x);
                if (o_item.near_b_y !== want.near_b_y)
                    report_mismatch("near_b_y", o_item.near_b_y, want.near_b_y);
                if (o_item.near_b_z !== want.near_b_z)
                    report_mismatch("near_b_z", o_item.near_b_z, want.near_b_z);
            end
        end
    end

    // send one item, entered and left at a falling edge
    task automatic send_item(t_in v, t_out want, int idle_pct);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= v;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
                pending_points = {pending_points, want};
            end
            @(negedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_coord(int mode);
        case (mode)
            0:       return $urandom;
            1:       return $signed($urandom_range(2 * ONE * 64)) - ONE * 64;
            default: return $signed($urandom_range(2 * ONE)) - ONE;
        endcase
    endfunction

    function automatic t_in random_pair();
        t_in v;
        int  mode;
        int  kind;
        int  k;
        mode = $urandom_range(2);
        kind = $urandom_range(9);
        v.a_origin_x = pick_coord(mode); v.a_origin_y = pick_coord(mode);
        v.a_origin_z = pick_coord(mode); v.a_dir_x = pick_coord(mode);
        v.a_dir_y = pick_coord(mode);    v.a_dir_z = pick_coord(mode);
        v.b_origin_x = pick_coord(mode); v.b_origin_y = pick_coord(mode);
        v.b_origin_z = pick_coord(mode); v.b_dir_x = pick_coord(mode);
        v.b_dir_y = pick_coord(mode);    v.b_dir_z = pick_coord(mode);
        // parallel directions
        if (kind == 0) begin
            k = $signed($urandom_range(6)) - 3;
            v.b_dir_x = $signed(v.a_dir_x[31:4]) * k;
            v.b_dir_y = $signed(v.a_dir_y[31:4]) * k;
            v.b_dir_z = $signed(v.a_dir_z[31:4]) * k;
            v.a_dir_x = $signed(v.a_dir_x[31:4]);
            v.a_dir_y = $signed(v.a_dir_y[31:4]);
            v.a_dir_z = $signed(v.a_dir_z[31:4]);
        end
        // degenerate direction
        if (kind == 1) begin
            v.a_dir_x = '0; v.a_dir_y = '0; v.a_dir_z = '0;
        end
        return v;
    endfunction

    initial begin
        t_row rows[$];
        t_row row;
        t_in  v;
        int   idle_pct;
        int   wait_cycles;

        mismatches = 0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all zero: degenerate
        row = '{item: '0, fixed: 1'b1, want: '0};
        rows = {rows, row};
        // all fields at maximum: identical lines are parallel
        row.item = {12{32'h7fffffff}};
        rows = {rows, row};
        // all fields at minimum: parallel too
        row.item = {12{32'h80000000}};
        rows = {rows, row};
        // x axis against y axis lifted in z
        row.item = '0;
        row.item.a_dir_x = ONE;
        row.item.b_dir_y = ONE;
        row.item.b_origin_z = 5 * ONE;
        row.want = '0;
        row.want.found = 1'b1;
        row.want.near_b_z = 5 * ONE;
        rows = {rows, row};
        // predictor-checked: skew lines, saturation, mixed extremes
        row.fixed = 1'b0;
        row.item = '0;
        row.item.a_dir_x = 32'sh7fffffff;
        row.item.b_dir_y = 1;
        row.item.b_origin_x = 32'sh80000000;
        row.item.a_origin_x = 32'sh7fffffff;
        rows = {rows, row};
        row.item = {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                    32'sh7fffffff, 32'sh1, 32'sh80000000, 32'sh7fffffff, 32'sh0,
                    32'sh1, 32'sh80000000, 32'sh7fffffff};
        rows = {rows, row};
        row.item = {32'hffffffff, 32'h0, 32'h1, 32'h1, 32'h2, 32'h3,
                    32'h7fffffff, 32'h80000000, 32'h0, 32'h3, 32'h1, 32'hffffffff};
        rows = {rows, row};
        for (int i = 0; i < 12; i++) begin
            row.item = random_pair();
            rows = {rows, row};
        end

        foreach (rows[i]) begin
            send_item(rows[i].item,
                      rows[i].fixed ? rows[i].want : closest_points(rows[i].item), 0);
        end

        // random phases: no idling, heavy idling, no idling again, light idling
        for (int n = 0; n < 900; n++) begin
            case (n / 225)
                0:       idle_pct = 0;
                1:       idle_pct = 62;
                2:       idle_pct = 0;
                default: idle_pct = 33;
            endcase
            v = random_pair();
            send_item(v, closest_points(v), idle_pct);
        end
        start <= 1'b0;

        // drain
        wait_cycles = 0;
        while (pending_points.size() != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (80) @(posedge i_clk);

        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // timeout
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
